// ===== hdl/c8ic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_pkg: shared types and constants for the chip-8 interpreter core
// holds request/response word types, item kinds and the font table
// ----------------------------------------------------------------------------
package c8ic_pkg;

   localparam int MemoryBytes  = 4096;
   localparam int ScreenWidth  = 64;
   localparam int ScreenHeight = 32;
   localparam int StackDepth   = 16;
   localparam logic [11:0] PcStart = 12'h200;
   localparam int FontBytes = 80;

   typedef enum logic [2:0] {
      KIND_EXEC  = 3'd0,
      KIND_TICK  = 3'd1,
      KIND_KEY   = 3'd2,
      KIND_MEMWR = 3'd3,
      KIND_ROWRD = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  key_index;
      logic        key_pressed;
      logic [11:0] mem_address;
      logic [7:0]  mem_data;
      logic [7:0]  random_byte;
      logic [4:0]  row_select;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic        sound_on;
      logic        waiting_for_key;
      logic        screen_changed;
      logic [63:0] row_pixels;
   } rsp_type;

   function automatic logic [7:0] font_byte(input logic [6:0] a);
      logic [7:0] r;
      case (a)
         7'd0: r = 8'hF0;  7'd1: r = 8'h90;  7'd2: r = 8'h90;  7'd3: r = 8'h90;
         7'd4: r = 8'hF0;  7'd5: r = 8'h20;  7'd6: r = 8'h60;  7'd7: r = 8'h20;
         7'd8: r = 8'h20;  7'd9: r = 8'h70;  7'd10: r = 8'hF0; 7'd11: r = 8'h10;
         7'd12: r = 8'hF0; 7'd13: r = 8'h80; 7'd14: r = 8'hF0; 7'd15: r = 8'hF0;
         7'd16: r = 8'h10; 7'd17: r = 8'hF0; 7'd18: r = 8'h10; 7'd19: r = 8'hF0;
         7'd20: r = 8'h90; 7'd21: r = 8'h90; 7'd22: r = 8'hF0; 7'd23: r = 8'h10;
         7'd24: r = 8'h10; 7'd25: r = 8'hF0; 7'd26: r = 8'h80; 7'd27: r = 8'hF0;
         7'd28: r = 8'h10; 7'd29: r = 8'hF0; 7'd30: r = 8'hF0; 7'd31: r = 8'h80;
         7'd32: r = 8'hF0; 7'd33: r = 8'h90; 7'd34: r = 8'hF0; 7'd35: r = 8'hF0;
         7'd36: r = 8'h10; 7'd37: r = 8'h20; 7'd38: r = 8'h40; 7'd39: r = 8'h40;
         7'd40: r = 8'hF0; 7'd41: r = 8'h90; 7'd42: r = 8'hF0; 7'd43: r = 8'h90;
         7'd44: r = 8'hF0; 7'd45: r = 8'hF0; 7'd46: r = 8'h90; 7'd47: r = 8'hF0;
         7'd48: r = 8'h10; 7'd49: r = 8'hF0; 7'd50: r = 8'hF0; 7'd51: r = 8'h90;
         7'd52: r = 8'hF0; 7'd53: r = 8'h90; 7'd54: r = 8'h90; 7'd55: r = 8'hE0;
         7'd56: r = 8'h90; 7'd57: r = 8'hE0; 7'd58: r = 8'h90; 7'd59: r = 8'hE0;
         7'd60: r = 8'hF0; 7'd61: r = 8'h80; 7'd62: r = 8'h80; 7'd63: r = 8'h80;
         7'd64: r = 8'hF0; 7'd65: r = 8'hE0; 7'd66: r = 8'h90; 7'd67: r = 8'h90;
         7'd68: r = 8'h90; 7'd69: r = 8'hE0; 7'd70: r = 8'hF0; 7'd71: r = 8'h80;
         7'd72: r = 8'hF0; 7'd73: r = 8'h80; 7'd74: r = 8'hF0; 7'd75: r = 8'hF0;
         7'd76: r = 8'h80; 7'd77: r = 8'hF0; 7'd78: r = 8'h80; 7'd79: r = 8'h80;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/chip8_interpreter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_interpreter_core: chip-8 virtual machine
// Each request word is taken when start is high and busy is low; busy stays
// high until the one response word appears on rsp_* with rsp_valid high for
// a single cycle, which the receiver must take: it cannot stall the block.
// A sequencer drives one memory port (one byte a cycle) and one screen row
// port. A sprite draw reads and writes its n rows in turn, a register dump
// and a register load move x+1 bytes, and a bcd store gets its digits from
// a subtract loop. After reset a clearing pass loads the font and zeroes
// memory, then the screen is cleared; busy is high meanwhile.
// ----------------------------------------------------------------------------
module chip8_interpreter_core #(
   parameter int STACK_DEPTH = c8ic_pkg::StackDepth
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  c8ic_pkg::req_type  req_word,
   output logic               rsp_valid,
   output c8ic_pkg::rsp_type  rsp_word
);

   localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [4:0] {
      ST_INIT, ST_SCLR, ST_IDLE, ST_DISP, ST_FETCH1, ST_FETCH2, ST_FETCH3,
      ST_DECODE, ST_RET, ST_CLR, ST_DRW_RD, ST_DRW_WAIT, ST_DRW_ROW,
      ST_DRW_WR, ST_BCD, ST_BCD_WR, ST_DUMP, ST_LOAD_RD, ST_LOAD_WAIT,
      ST_LOAD_WR, ST_ROWRD, ST_ROWWAIT, ST_DONE
   } state_type;

   // storage
   logic [7:0]  mem [c8ic_pkg::MemoryBytes];
   logic [63:0] scr [c8ic_pkg::ScreenHeight];
   logic [11:0] stk [STACK_DEPTH];

   state_type   state_ff;
   c8ic_pkg::req_type req_ff;
   logic [7:0]  v_ff [16];
   logic [11:0] i_ff, pc_ff;
   logic [SpW-1:0] sp_ff;
   logic [7:0]  dt_ff, st_ff;
   logic [15:0] keys_ff;
   logic        kwait_ff;
   logic [3:0]  ktgt_ff;
   logic [15:0] op_ff;
   logic [11:0] cnt_ff;
   logic [3:0]  row_ff;
   logic [7:0]  rd_ff;
   logic [63:0] srow_ff;
   logic        hit_ff, chg_ff;
   logic [7:0]  bcd_ff;
   logic [3:0]  dig_ff [3];
   logic [1:0]  dsel_ff;
   logic        rsp_valid_ff;
   logic [63:0] pix_ff;

   // memory port
   logic        mwe;
   logic [11:0] maddr;
   logic [7:0]  mwdata;
   // screen port
   logic        swe;
   logic [4:0]  saddr;
   logic [63:0] swdata;

   always_ff @(posedge clock) begin
      if (mwe) begin
         mem[maddr] <= mwdata;
      end
      rd_ff <= mem[maddr];
      if (swe) begin
         scr[saddr] <= swdata;
      end
      srow_ff <= scr[saddr];
   end

   logic [3:0]  ox, oy, on;
   logic [7:0]  okk;
   logic [11:0] onnn;
   logic [7:0]  vx, vy;
   logic [5:0]  cx;
   logic [4:0]  cy;
   logic [63:0] spr_mask;
   logic [8:0]  sum9;
   logic [11:0] pc2;
   logic [6:0]  fidx;

   assign ox   = op_ff[11:8];
   assign oy   = op_ff[7:4];
   assign on   = op_ff[3:0];
   assign okk  = op_ff[7:0];
   assign onnn = op_ff[11:0];
   assign vx   = v_ff[ox];
   assign vy   = v_ff[oy];
   assign cx   = vx[5:0];
   assign cy   = vy[4:0];
   assign pc2  = pc_ff + 12'd2;
   assign sum9 = {1'b0, vx} + {1'b0, vy};
   assign spr_mask = ({rd_ff, 56'd0} >> cx) | ({rd_ff, 56'd0} << (7'd64 - {1'b0, cx}));
   assign fidx = cnt_ff[6:0];

   always_comb begin
      mwe = 1'b0; maddr = cnt_ff; mwdata = 8'd0;
      swe = 1'b0; saddr = cnt_ff[4:0]; swdata = 64'd0;
      unique case (state_ff)
         ST_INIT: begin
            mwe = 1'b1;
            mwdata = (cnt_ff < 12'(c8ic_pkg::FontBytes)) ? c8ic_pkg::font_byte(fidx) : 8'd0;
         end
         ST_SCLR, ST_CLR: begin
            swe = 1'b1;
         end
         ST_DISP: begin
            maddr = req_ff.mem_address;
            mwdata = req_ff.mem_data;
            mwe = (req_ff.kind == c8ic_pkg::KIND_MEMWR);
            saddr = req_ff.row_select;
         end
         ST_FETCH1: maddr = pc_ff;
         ST_FETCH2: maddr = pc_ff + 12'd1;
         ST_DRW_RD: maddr = i_ff + 12'(row_ff);
         ST_DRW_WAIT: begin
            maddr = i_ff + 12'(row_ff);
            saddr = cy + 5'(row_ff);
         end
         ST_DRW_WR: begin
            saddr = cy + 5'(row_ff);
            swe = 1'b1;
            swdata = srow_ff ^ spr_mask;
         end
         ST_BCD_WR: begin
            maddr = i_ff + 12'(dsel_ff);
            mwe = 1'b1;
            mwdata = {4'd0, dig_ff[dsel_ff]};
         end
         ST_DUMP: begin
            maddr = i_ff + cnt_ff;
            mwe = 1'b1;
            mwdata = v_ff[cnt_ff[3:0]];
         end
         ST_LOAD_RD, ST_LOAD_WAIT: maddr = i_ff + cnt_ff;
         ST_ROWRD: saddr = req_ff.row_select;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff <= 12'd0;
         for (int k = 0; k < 16; k++) begin
            v_ff[k] <= 8'd0;
         end
         for (int k = 0; k < STACK_DEPTH; k++) begin
            stk[k] <= 12'd0;
         end
         i_ff <= 12'd0; pc_ff <= c8ic_pkg::PcStart; sp_ff <= '0;
         dt_ff <= 8'd0; st_ff <= 8'd0; keys_ff <= 16'd0;
         kwait_ff <= 1'b0; ktgt_ff <= 4'd0; rsp_valid_ff <= 1'b0;
         chg_ff <= 1'b0; pix_ff <= 64'd0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff == 12'(c8ic_pkg::MemoryBytes - 1)) begin
                  cnt_ff <= 12'd0;
                  state_ff <= ST_SCLR;
               end
            end
            ST_SCLR, ST_CLR: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff[4:0] == 5'(c8ic_pkg::ScreenHeight - 1)) begin
                  state_ff <= (state_ff == ST_SCLR) ? ST_IDLE : ST_DONE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  req_ff <= req_word;
                  chg_ff <= 1'b0;
                  pix_ff <= 64'd0;
                  state_ff <= ST_DISP;
               end
            end
            ST_DISP: begin
               state_ff <= ST_DONE;
               case (req_ff.kind)
                  c8ic_pkg::KIND_EXEC: if (!kwait_ff) state_ff <= ST_FETCH1;
                  c8ic_pkg::KIND_TICK: begin
                     if (dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
                     if (st_ff != 8'd0) st_ff <= st_ff - 8'd1;
                  end
                  c8ic_pkg::KIND_KEY: begin
                     if (req_ff.key_pressed) begin
                        keys_ff[req_ff.key_index] <= 1'b1;
                        if (kwait_ff) begin
                           v_ff[ktgt_ff] <= {4'd0, req_ff.key_index};
                           kwait_ff <= 1'b0;
                        end
                     end else begin
                        keys_ff[req_ff.key_index] <= 1'b0;
                     end
                  end
                  c8ic_pkg::KIND_ROWRD: state_ff <= ST_ROWWAIT;
                  default: ;
               endcase
            end
            ST_ROWWAIT: begin
               pix_ff <= srow_ff;
               state_ff <= ST_DONE;
            end
            ST_FETCH1: state_ff <= ST_FETCH2;
            ST_FETCH2: begin
               op_ff[15:8] <= rd_ff;
               state_ff <= ST_FETCH3;
            end
            ST_FETCH3: begin
               op_ff[7:0] <= rd_ff;
               pc_ff <= pc2;
               state_ff <= ST_DECODE;
            end
            ST_DECODE: begin
               state_ff <= ST_DONE;
               cnt_ff <= 12'd0;
               row_ff <= 4'd0;
               case (op_ff[15:12])
                  4'h0: begin
                     if (op_ff == 16'h00E0) begin
                        chg_ff <= 1'b1;
                        state_ff <= ST_CLR;
                     end else if (op_ff == 16'h00EE) begin
                        sp_ff <= (sp_ff == '0) ? SpW'(STACK_DEPTH - 1) : sp_ff - SpW'(1);
                        state_ff <= ST_RET;
                     end
                  end
                  4'h1: pc_ff <= onnn;
                  4'h2: begin
                     stk[sp_ff] <= pc_ff;
                     sp_ff <= (sp_ff == SpW'(STACK_DEPTH - 1)) ? '0 : sp_ff + SpW'(1);
                     pc_ff <= onnn;
                  end
                  4'h3: if (vx == okk) pc_ff <= pc2;
                  4'h4: if (vx != okk) pc_ff <= pc2;
                  4'h5: if (vx == vy) pc_ff <= pc2;
                  4'h6: v_ff[ox] <= okk;
                  4'h7: v_ff[ox] <= vx + okk;
                  4'h8: begin
                     case (on)
                        4'h0: v_ff[ox] <= vy;
                        4'h1: v_ff[ox] <= vx | vy;
                        4'h2: v_ff[ox] <= vx & vy;
                        4'h3: v_ff[ox] <= vx ^ vy;
                        4'h4: begin
                           v_ff[ox] <= sum9[7:0];
                           v_ff[15] <= {7'd0, sum9[8]};
                        end
                        4'h5: begin
                           v_ff[ox] <= vx - vy;
                           v_ff[15] <= {7'd0, vx >= vy};
                        end
                        4'h6: begin
                           v_ff[ox] <= vx >> 1;
                           v_ff[15] <= {7'd0, vx[0]};
                        end
                        4'h7: begin
                           v_ff[ox] <= vy - vx;
                           v_ff[15] <= {7'd0, vy >= vx};
                        end
                        4'hE: begin
                           v_ff[ox] <= vx << 1;
                           v_ff[15] <= {7'd0, vx[7]};
                        end
                        default: ;
                     endcase
                  end
                  4'h9: if (vx != vy) pc_ff <= pc2;
                  4'hA: i_ff <= onnn;
                  4'hB: pc_ff <= onnn + {4'd0, v_ff[0]};
                  4'hC: v_ff[ox] <= req_ff.random_byte & okk;
                  4'hD: begin
                     chg_ff <= 1'b1;
                     hit_ff <= 1'b0;
                     state_ff <= (on == 4'd0) ? ST_DRW_ROW : ST_DRW_RD;
                  end
                  4'hE: begin
                     if ((okk == 8'h9E && keys_ff[vx[3:0]]) ||
                         (okk == 8'hA1 && !keys_ff[vx[3:0]])) pc_ff <= pc2;
                  end
                  default: begin
                     case (okk)
                        8'h07: v_ff[ox] <= dt_ff;
                        8'h0A: begin
                           kwait_ff <= 1'b1;
                           ktgt_ff <= ox;
                        end
                        8'h15: dt_ff <= vx;
                        8'h18: st_ff <= vx;
                        8'h1E: i_ff <= i_ff + {4'd0, vx};
                        8'h29: i_ff <= {2'd0, vx, 2'd0} + {4'd0, vx};
                        8'h33: begin
                           bcd_ff <= vx;
                           dsel_ff <= 2'd0;
                           dig_ff[0] <= 4'd0; dig_ff[1] <= 4'd0; dig_ff[2] <= 4'd0;
                           state_ff <= ST_BCD;
                        end
                        8'h55: state_ff <= ST_DUMP;
                        8'h65: state_ff <= ST_LOAD_RD;
                        default: ;
                     endcase
                  end
               endcase
            end
            ST_RET: begin
               pc_ff <= stk[sp_ff];
               state_ff <= ST_DONE;
            end
            ST_DRW_RD: state_ff <= ST_DRW_WAIT;
            ST_DRW_WAIT: state_ff <= ST_DRW_WR;
            ST_DRW_WR: begin
               if ((srow_ff & spr_mask) != 64'd0) hit_ff <= 1'b1;
               row_ff <= row_ff + 4'd1;
               state_ff <= (row_ff + 4'd1 == on) ? ST_DRW_ROW : ST_DRW_RD;
            end
            ST_DRW_ROW: begin
               v_ff[15] <= {7'd0, hit_ff};
               state_ff <= ST_DONE;
            end
            ST_BCD: begin
               // repeated subtraction: hundreds then tens
               if (dsel_ff == 2'd0 && bcd_ff >= 8'd100) begin
                  bcd_ff <= bcd_ff - 8'd100;
                  dig_ff[0] <= dig_ff[0] + 4'd1;
               end else if (dsel_ff == 2'd0) begin
                  dsel_ff <= 2'd1;
               end else if (bcd_ff >= 8'd10) begin
                  bcd_ff <= bcd_ff - 8'd10;
                  dig_ff[1] <= dig_ff[1] + 4'd1;
               end else begin
                  dig_ff[2] <= bcd_ff[3:0];
                  dsel_ff <= 2'd0;
                  state_ff <= ST_BCD_WR;
               end
            end
            ST_BCD_WR: begin
               dsel_ff <= dsel_ff + 2'd1;
               if (dsel_ff == 2'd2) state_ff <= ST_DONE;
            end
            ST_DUMP: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff[3:0] == ox) state_ff <= ST_DONE;
            end
            ST_LOAD_RD: state_ff <= ST_LOAD_WAIT;
            ST_LOAD_WAIT: state_ff <= ST_LOAD_WR;
            ST_LOAD_WR: begin
               v_ff[cnt_ff[3:0]] <= rd_ff;
               cnt_ff <= cnt_ff + 12'd1;
               state_ff <= (cnt_ff[3:0] == ox) ? ST_DONE : ST_LOAD_RD;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_word.program_counter = pc_ff;
      rsp_word.sound_on        = (st_ff != 8'd0);
      rsp_word.waiting_for_key = kwait_ff;
      rsp_word.screen_changed  = chg_ff;
      rsp_word.row_pixels      = pix_ff;
   end

`ifndef SYNTHESIS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("response without done");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy at response");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid)
      else $error("accept did not start work");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for chip8_interpreter_core
// Directed tests for each instruction group, the key wait, the timers, the
// screen and memory wrap, then random programs. Each instruction is loaded
// at the pc and run. A behavioral machine predicts every response word, and
// each response is checked in order against it.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [7:0] FX_GET_DT = 8'h07, FX_WAIT_KEY = 8'h0A, FX_SET_DT = 8'h15,
      FX_SET_ST = 8'h18, FX_ADD_I = 8'h1E, FX_FONT = 8'h29, FX_BCD = 8'h33,
      FX_STORE = 8'h55, FX_LOAD = 8'h65;
   localparam logic [7:0] EX_SKIP_DOWN = 8'h9E, EX_SKIP_UP = 8'hA1;
   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   c8ic_pkg::req_type req_word = '0;
   logic busy, rsp_valid;
   c8ic_pkg::rsp_type rsp_word;

   chip8_interpreter_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   // machine state
   logic [7:0]  mem [c8ic_pkg::MemoryBytes];
   logic [7:0]  vreg [16];
   logic [11:0] stk [16];
   logic [11:0] ireg, pcr;
   logic [3:0]  sp;
   logic [7:0]  dtimer, stimer;
   logic [63:0] screen [c8ic_pkg::ScreenHeight];
   logic [15:0] keys;
   logic        kwait;
   logic [3:0]  ktarget;

   c8ic_pkg::rsp_type expected_q[$];
   int fails = 0;
   int idle_cycles = 0;

   localparam logic [7:0] Glyphs [80] = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
   };

   function automatic void clear_machine();
      for (int i = 0; i < c8ic_pkg::MemoryBytes; i++) mem[i] = (i < 80) ? Glyphs[i] : 8'h00;
      for (int i = 0; i < 16; i++) begin
         vreg[i] = '0;
         stk[i] = '0;
      end
      for (int i = 0; i < c8ic_pkg::ScreenHeight; i++) screen[i] = '0;
      ireg = '0; pcr = c8ic_pkg::PcStart; sp = '0; dtimer = '0; stimer = '0;
      keys = '0; kwait = 1'b0; ktarget = '0;
   endfunction

   function automatic logic run_instruction(logic [7:0] rnd);
      logic [15:0] op;
      logic [3:0] x, y, n;
      logic [7:0] kk, r;
      logic [8:0] wide;
      logic [5:0] px;
      logic [4:0] py;
      logic [7:0] b;
      logic hit, changed, flag;
      op = {mem[pcr], mem[pcr + 12'd1]};
      x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
      changed = 1'b0;
      pcr = pcr + 12'd2;
      case (op[15:12])
         4'h0: begin
            if (op == OP_CLS) begin
               for (int i = 0; i < c8ic_pkg::ScreenHeight; i++) screen[i] = '0;
               changed = 1'b1;
            end else if (op == OP_RET) begin
               sp = sp - 4'd1;
               pcr = stk[sp];
            end
         end
         4'h1: pcr = op[11:0];
         4'h2: begin
            stk[sp] = pcr;
            sp = sp + 4'd1;
            pcr = op[11:0];
         end
         4'h3: if (vreg[x] == kk) pcr = pcr + 12'd2;
         4'h4: if (vreg[x] != kk) pcr = pcr + 12'd2;
         4'h5: if (vreg[x] == vreg[y]) pcr = pcr + 12'd2;
         4'h6: vreg[x] = kk;
         4'h7: vreg[x] = vreg[x] + kk;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = vreg[y];
               4'h1: vreg[x] = vreg[x] | vreg[y];
               4'h2: vreg[x] = vreg[x] & vreg[y];
               4'h3: vreg[x] = vreg[x] ^ vreg[y];
               4'h4: begin
                  wide = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                  vreg[x] = wide[7:0]; vreg[15] = {7'd0, wide[8]};
               end
               4'h5: begin
                  flag = vreg[x] >= vreg[y];
                  vreg[x] = vreg[x] - vreg[y]; vreg[15] = {7'd0, flag};
               end
               4'h6: begin
                  flag = vreg[x][0];
                  vreg[x] = vreg[x] >> 1; vreg[15] = {7'd0, flag};
               end
               4'h7: begin
                  flag = vreg[y] >= vreg[x];
                  vreg[x] = vreg[y] - vreg[x]; vreg[15] = {7'd0, flag};
               end
               4'hE: begin
                  flag = vreg[x][7];
                  vreg[x] = vreg[x] << 1; vreg[15] = {7'd0, flag};
               end
               default: ;
            endcase
         end
         4'h9: if (vreg[x] != vreg[y]) pcr = pcr + 12'd2;
         4'hA: ireg = op[11:0];
         4'hB: pcr = op[11:0] + {4'd0, vreg[0]};
         4'hC: vreg[x] = rnd & kk;
         4'hD: begin
            hit = 1'b0;
            for (int row = 0; row < n; row++) begin
               b = mem[ireg + 12'(row)];
               py = vreg[y][4:0] + 5'(row);
               for (int c = 0; c < 8; c++) begin
                  if (b[7 - c]) begin
                     px = vreg[x][5:0] + 6'(c);
                     if (screen[py][63 - px]) hit = 1'b1;
                     screen[py][63 - px] = ~screen[py][63 - px];
                  end
               end
            end
            vreg[15] = {7'd0, hit};
            changed = 1'b1;
         end
         4'hE: begin
            flag = keys[vreg[x][3:0]];
            if ((kk == EX_SKIP_DOWN && flag) || (kk == EX_SKIP_UP && !flag))
               pcr = pcr + 12'd2;
         end
         default: begin
            case (kk)
               FX_GET_DT: vreg[x] = dtimer;
               FX_WAIT_KEY: begin
                  kwait = 1'b1; ktarget = x;
               end
               FX_SET_DT: dtimer = vreg[x];
               FX_SET_ST: stimer = vreg[x];
               FX_ADD_I: ireg = ireg + {4'd0, vreg[x]};
               FX_FONT: ireg = 12'(vreg[x] * 5);
               FX_BCD: begin
                  r = vreg[x];
                  mem[ireg] = r / 100;
                  mem[ireg + 12'd1] = (r / 10) % 10;
                  mem[ireg + 12'd2] = r % 10;
               end
               FX_STORE: for (int i = 0; i <= x; i++) mem[ireg + 12'(i)] = vreg[i];
               FX_LOAD: for (int i = 0; i <= x; i++) vreg[i] = mem[ireg + 12'(i)];
               default: ;
            endcase
         end
      endcase
      return changed;
   endfunction

   function automatic c8ic_pkg::rsp_type predict_response(c8ic_pkg::req_type w);
      c8ic_pkg::rsp_type e;
      e = '0;
      case (w.kind)
         c8ic_pkg::KIND_EXEC: if (!kwait) e.screen_changed = run_instruction(w.random_byte);
         c8ic_pkg::KIND_TICK: begin
            if (dtimer != 0) dtimer--;
            if (stimer != 0) stimer--;
         end
         c8ic_pkg::KIND_KEY: begin
            if (w.key_pressed) begin
               keys[w.key_index] = 1'b1;
               if (kwait) begin
                  vreg[ktarget] = {4'd0, w.key_index};
                  kwait = 1'b0;
               end
            end else begin
               keys[w.key_index] = 1'b0;
            end
         end
         c8ic_pkg::KIND_MEMWR: mem[w.mem_address] = w.mem_data;
         c8ic_pkg::KIND_ROWRD: e.row_pixels = screen[w.row_select];
         default: ;
      endcase
      e.program_counter = pcr;
      e.sound_on = stimer != 0;
      e.waiting_for_key = kwait;
      return e;
   endfunction

   always @(posedge clock) begin
      c8ic_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected");
            fails++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_word.program_counter !== e.program_counter) begin
               $error("program_counter exp %h got %h", e.program_counter,
                      rsp_word.program_counter);
               fails++;
            end
            if (rsp_word.sound_on !== e.sound_on) begin
               $error("sound_on exp %b got %b", e.sound_on, rsp_word.sound_on);
               fails++;
            end
            if (rsp_word.waiting_for_key !== e.waiting_for_key) begin
               $error("waiting_for_key exp %b got %b", e.waiting_for_key,
                      rsp_word.waiting_for_key);
               fails++;
            end
            if (rsp_word.screen_changed !== e.screen_changed) begin
               $error("screen_changed exp %b got %b", e.screen_changed,
                      rsp_word.screen_changed);
               fails++;
            end
            if (rsp_word.row_pixels !== e.row_pixels) begin
               $error("row_pixels exp %h got %h", e.row_pixels, rsp_word.row_pixels);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL chip8_interpreter_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic c8ic_pkg::req_type random_word(c8ic_pkg::kind_type k);
      c8ic_pkg::req_type w;
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      w = bits[$bits(c8ic_pkg::req_type)-1:0];
      w.kind = k;
      return w;
   endfunction

   // start stays high; every send is followed by another send or a gap
   task automatic send_word(c8ic_pkg::req_type w);
      @(negedge clock);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      expected_q.push_back(predict_response(w));
   endtask

   task automatic gap(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      gap(1);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_byte(logic [11:0] a, logic [7:0] d);
      c8ic_pkg::req_type w;
      w = random_word(c8ic_pkg::KIND_MEMWR);
      w.mem_address = a;
      w.mem_data = d;
      send_word(w);
   endtask

   task automatic run_op(logic [15:0] op);
      write_byte(pcr, op[15:8]);
      write_byte(pcr + 12'd1, op[7:0]);
      send_word(random_word(c8ic_pkg::KIND_EXEC));
   endtask

   task automatic key_event(logic [3:0] k, logic down);
      c8ic_pkg::req_type w;
      w = random_word(c8ic_pkg::KIND_KEY);
      w.key_index = k;
      w.key_pressed = down;
      send_word(w);
   endtask

   task automatic read_row(logic [4:0] r);
      c8ic_pkg::req_type w;
      w = random_word(c8ic_pkg::KIND_ROWRD);
      w.row_select = r;
      send_word(w);
   endtask

   task automatic test_boot_state();
      read_row(5'd0);
      read_row(5'd31);
      send_word(random_word(c8ic_pkg::KIND_TICK));
      // kinds past the last one have no effect
      send_word(random_word(c8ic_pkg::kind_type'(3'd5)));
      send_word(random_word(c8ic_pkg::kind_type'(3'd7)));
      drain();
   endtask

   task automatic test_alu();
      run_op(16'h60FF); run_op(16'h6101); run_op(16'h8014);
      run_op(16'h6FFF); run_op(16'h8F14); run_op(16'h8015);
      run_op(16'h8107); run_op(16'h60A5); run_op(16'h8006);
      run_op(16'h800E); run_op(16'h8011); run_op(16'h8012);
      run_op(16'h8013); run_op(16'h8019); run_op(16'h70FF);
      run_op(16'h3000); run_op(16'h40FF); run_op(16'h5010);
      run_op(16'h9010); run_op(16'hC3FF); run_op(16'h0123);
      drain();
   endtask

   task automatic test_sprite_wrap();
      run_op(OP_CLS);
      run_op(16'h60FF); run_op(16'h61FF); run_op(16'hA000);
      run_op(16'hD01F);
      read_row(5'd31); read_row(5'd0);
      run_op(16'hD015);
      read_row(5'd31);
      run_op(16'hF029); run_op(16'hF01E); run_op(16'hD010);
      drain();
   endtask

   task automatic test_flow();
      run_op(16'h2400); run_op(16'h2600); run_op(OP_RET); run_op(OP_RET);
      run_op(OP_RET);
      run_op(16'h1FFE); run_op(16'h6004); run_op(16'hBFFE);
      drain();
   endtask

   task automatic test_keys_timers();
      run_op(16'h6007);
      run_op(16'hE09E); run_op(16'hE0A1);
      key_event(4'd7, 1'b1);
      run_op(16'hE09E); run_op(16'hE0A1);
      run_op(16'hF50A);
      send_word(random_word(c8ic_pkg::KIND_EXEC));
      key_event(4'd3, 1'b0);
      key_event(4'd15, 1'b1);
      key_event(4'd7, 1'b0);
      run_op(16'hF518); run_op(16'hF515); run_op(16'hF207);
      repeat (16) send_word(random_word(c8ic_pkg::KIND_TICK));
      run_op(16'hF207);
      drain();
   endtask

   task automatic test_memory_wrap();
      run_op(16'h60FF); run_op(16'hAFFE); run_op(16'hF033);
      run_op(16'hAFF8); run_op(16'hFF55); run_op(16'hFF65);
      run_op(16'hF5FF);
      write_byte(12'hFFF, 8'hFF);
      write_byte(12'h000, 8'h00);
      drain();
   endtask

   function automatic logic [15:0] random_op();
      logic [15:0] op;
      logic [7:0] fx [9];
      fx = '{FX_GET_DT, FX_WAIT_KEY, FX_SET_DT, FX_SET_ST, FX_ADD_I, FX_FONT,
             FX_BCD, FX_STORE, FX_LOAD};
      op = 16'($urandom);
      case (op[15:12])
         4'h0: case ($urandom_range(0, 3))
            0: op = OP_CLS;
            1, 2: op = OP_RET;
            default: ;
         endcase
         4'h8: if ($urandom_range(0, 7) != 0)
            op[3:0] = ($urandom_range(0, 8) == 8) ? 4'hE : 4'($urandom_range(0, 7));
         4'hD: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
         4'hE: if ($urandom_range(0, 7) != 0)
            op[7:0] = $urandom_range(0, 1) ? EX_SKIP_DOWN : EX_SKIP_UP;
         4'hF: if ($urandom_range(0, 7) != 0) op[7:0] = fx[$urandom_range(0, 8)];
         default: ;
      endcase
      return op;
   endfunction

   task automatic test_random_programs();
      int burst;
      int pick;
      burst = 0;
      repeat (490) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) run_op(random_op());
         else if (pick < 17) key_event(4'($urandom), 1'($urandom));
         else if (pick < 18) send_word(random_word(c8ic_pkg::KIND_TICK));
         else if (pick < 19) read_row(5'($urandom));
         else send_word(random_word(c8ic_pkg::kind_type'($urandom_range(0, 7))));
         if (kwait && $urandom_range(0, 2) == 0) key_event(4'($urandom), 1'b1);
         if (burst == 0) begin
            gap($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 25));
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
         end else begin
            burst--;
         end
      end
      drain();
   endtask

   initial begin
      clear_machine();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_boot_state();
      test_alu();
      test_sprite_wrap();
      test_flow();
      test_keys_timers();
      test_memory_wrap();
      test_random_programs();
      repeat (100) @(posedge clock);
      if (fails == 0 && expected_q.size() == 0) begin
         $display("PASS chip8_interpreter_core");
      end else begin
         $display("FAIL chip8_interpreter_core");
      end
      $finish;
   end

endmodule
